@@ rtl/core/pfa_pkg.sv @@
// shared constants, codes and controller/datapath interface types
package pfa_pkg;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_COLOR_BITS = 16;
    localparam int DEF_FRAME_BITS = 16;
    localparam int DEF_TIME_BITS  = 16;

    // item command codes
    localparam logic [1:0] CMD_ADD   = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_HOLD   = 2'd2;
    localparam logic [1:0] CFG_FADE   = 2'd3;

    // configuration reset values
    localparam logic [8:0]  RST_DIM  = 9'd256;
    localparam logic [15:0] RST_HOLD = 16'd10;
    localparam logic [15:0] RST_FADE = 16'd10;

    typedef struct packed {
        logic load_item;
        logic set_newest;
        logic sweep_init;
        logic sweep_step;
        logic area_step;
        logic restamp_wr;
        logic clear_wr;
        logic tick_inc;
        logic tick_rd;
        logic tick_wr;
        logic pix_rd;
        logic pix_wr;
        logic res_zero;
        logic res_applied;
        logic emit;
        logic clr_ack;
    } t_dp_cmd;

    typedef struct packed {
        logic       clr_pend;
        logic [1:0] cmd;
        logic       stale;
        logic       newer;
        logic       in_range;
        logic       full_last;
        logic       area_last;
        logic       area_empty;
        logic       out_free;
    } t_dp_stat;

endpackage

@@ rtl/core/pfa_ram.sv @@
// generic single-write, single-read ram with registered read
module pfa_ram #(
    parameter int WIDTH     = 8,
    parameter int DEPTH     = 16,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/pfa_ctrl.sv @@
// sequencing state machine for the frame accumulator
module pfa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pfa_pkg::t_dp_stat i_stat,
    output pfa_pkg::t_dp_cmd  o_cmd
);
    import pfa_pkg::*;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DECODE  = 3'd1;
    localparam logic [2:0] ST_RESTAMP = 3'd2;
    localparam logic [2:0] ST_CLEAR   = 3'd3;
    localparam logic [2:0] ST_TICK_RD = 3'd4;
    localparam logic [2:0] ST_TICK_WR = 3'd5;
    localparam logic [2:0] ST_PIX_WR  = 3'd6;
    localparam logic [2:0] ST_EMIT    = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_clr_item, n_clr_item;
    t_dp_cmd    cmd;

    assign o_in_ready = (r_state == ST_IDLE) && !i_stat.clr_pend;
    assign o_cmd      = cmd;

    always_comb begin
        cmd        = '0;
        n_state    = r_state;
        n_clr_item = r_clr_item;
        unique case (r_state)
            ST_IDLE: begin
                if (i_stat.clr_pend) begin
                    cmd.clr_ack    = 1'b1;
                    cmd.sweep_init = 1'b1;
                    n_clr_item     = 1'b0;
                    n_state        = ST_CLEAR;
                end else if (i_in_valid) begin
                    cmd.load_item = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (i_stat.cmd)
                    CMD_ADD: begin
                        if (i_stat.stale) begin
                            cmd.res_zero = 1'b1;
                            n_state      = ST_EMIT;
                        end else if (i_stat.newer) begin
                            cmd.set_newest = 1'b1;
                            cmd.sweep_init = 1'b1;
                            n_state        = ST_RESTAMP;
                        end else if (i_stat.in_range) begin
                            cmd.pix_rd = 1'b1;
                            n_state    = ST_PIX_WR;
                        end else begin
                            cmd.res_zero = 1'b1;
                            n_state      = ST_EMIT;
                        end
                    end
                    CMD_TICK: begin
                        cmd.tick_inc    = 1'b1;
                        cmd.sweep_init  = 1'b1;
                        cmd.res_zero    = 1'b1;
                        cmd.res_applied = 1'b1;
                        n_state = i_stat.area_empty ? ST_EMIT : ST_TICK_RD;
                    end
                    CMD_READ: begin
                        if (i_stat.in_range) begin
                            cmd.pix_rd = 1'b1;
                            n_state    = ST_PIX_WR;
                        end else begin
                            cmd.res_zero = 1'b1;
                            n_state      = ST_EMIT;
                        end
                    end
                    CMD_CLEAR: begin
                        cmd.sweep_init = 1'b1;
                        n_clr_item     = 1'b1;
                        n_state        = ST_CLEAR;
                    end
                    default: n_state = ST_IDLE;
                endcase
            end
            ST_RESTAMP: begin
                cmd.restamp_wr = 1'b1;
                cmd.sweep_step = 1'b1;
                if (i_stat.full_last) begin
                    if (i_stat.in_range) begin
                        cmd.pix_rd = 1'b1;
                        n_state    = ST_PIX_WR;
                    end else begin
                        cmd.res_zero = 1'b1;
                        n_state      = ST_EMIT;
                    end
                end
            end
            ST_CLEAR: begin
                cmd.clear_wr   = 1'b1;
                cmd.sweep_step = 1'b1;
                if (i_stat.full_last) begin
                    if (r_clr_item) begin
                        cmd.res_zero    = 1'b1;
                        cmd.res_applied = 1'b1;
                        n_state         = ST_EMIT;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_TICK_RD: begin
                cmd.tick_rd = 1'b1;
                n_state     = ST_TICK_WR;
            end
            ST_TICK_WR: begin
                cmd.tick_wr = 1'b1;
                if (i_stat.area_last) begin
                    n_state = ST_EMIT;
                end else begin
                    cmd.area_step = 1'b1;
                    n_state       = ST_TICK_RD;
                end
            end
            ST_PIX_WR: begin
                cmd.pix_wr = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    cmd.emit = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_clr_item <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_item <= n_clr_item;
        end
    end

endmodule

@@ rtl/core/pfa_datapath.sv @@
// pixel stores, configuration registers, sweep counters and color arithmetic
module pfa_datapath #(
    parameter int MAX_WIDTH  = pfa_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = pfa_pkg::DEF_MAX_HEIGHT,
    parameter int COLOR_BITS = pfa_pkg::DEF_COLOR_BITS,
    parameter int FRAME_BITS = pfa_pkg::DEF_FRAME_BITS,
    parameter int TIME_BITS  = pfa_pkg::DEF_TIME_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    input  logic [1:0]         i_command,
    input  logic [7:0]         i_pos_x,
    input  logic [7:0]         i_pos_y,
    input  logic [15:0]        i_frame_number,
    input  logic signed [15:0] i_sample_red,
    input  logic signed [15:0] i_sample_green,
    input  logic signed [15:0] i_sample_blue,
    input  logic               i_out_ready,
    input  pfa_pkg::t_dp_cmd   i_cmd,
    output pfa_pkg::t_dp_stat  o_stat,
    output logic               o_out_valid,
    output logic signed [15:0] o_pixel_red,
    output logic signed [15:0] o_pixel_green,
    output logic signed [15:0] o_pixel_blue,
    output logic [15:0]        o_pixel_frame,
    output logic               o_applied
);
    import pfa_pkg::*;

    localparam int CB    = COLOR_BITS;
    localparam int FB    = FRAME_BITS;
    localparam int TB    = TIME_BITS;
    localparam int NPIX  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(NPIX);
    localparam int WB    = $clog2(MAX_WIDTH + 1);
    localparam int HB    = $clog2(MAX_HEIGHT + 1);
    localparam int DW    = 6 * CB + 2 * FB;
    localparam int O_VF  = 3 * CB;
    localparam int O_ST  = 3 * CB + FB;
    localparam int O_SF  = 6 * CB + FB;
    localparam int SW    = ((CB > 16) ? CB : 16) + 1;
    localparam int OW    = SW - 1;
    localparam int RSH   = CB + 8;
    localparam logic [CB+4:0] RECIP = (CB+5)'((64'd1 << RSH) / 64'd10);
    localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};
    localparam logic signed [OW-1:0] O_HI  = OW'(32'sd32767);
    localparam logic signed [OW-1:0] O_LO  = OW'(-32'sd32768);

    // saturating add of a sample channel
    function automatic logic signed [CB-1:0] sat_add(input logic signed [CB-1:0] a,
                                                     input logic signed [15:0] b);
        logic signed [SW-1:0] sum;
        sum = SW'(a) + SW'(b);
        if (sum > SW'(C_MAX)) begin
            return C_MAX;
        end else if (sum < SW'(C_MIN)) begin
            return C_MIN;
        end
        return CB'(sum);
    endfunction

    // clamp a stored channel to the 16-bit output
    function automatic logic [15:0] sat16(input logic signed [CB-1:0] v);
        logic signed [OW-1:0] e;
        e = OW'(v);
        if (e > O_HI) begin
            e = O_HI;
        end else if (e < O_LO) begin
            e = O_LO;
        end
        return e[15:0];
    endfunction

    // times 9/10, truncated toward zero; /10 by reciprocal and one correction
    function automatic logic signed [CB-1:0] scale_9_10(input logic signed [CB-1:0] v);
        logic [CB-1:0]     m;
        logic [CB+3:0]     p;
        logic [2*CB+8:0]   prod;
        logic [CB+3:0]     q;
        logic [CB+3:0]     r;
        m    = v[CB-1] ? CB'(-v) : CB'(v);
        p    = (CB+4)'(m) * (CB+4)'(9);
        prod = (2*CB+9)'(p) * (2*CB+9)'(RECIP);
        q    = (CB+4)'(prod >> RSH);
        r    = p - (CB+4)'(q * (CB+4)'(10));
        if (r >= (CB+4)'(10)) begin
            q = q + 1'b1;
        end
        return CB'(v[CB-1] ? -q : q);
    endfunction

    // configuration
    logic [8:0]  r_width, r_height;
    logic [15:0] r_hold, r_fade;
    logic        r_clr_pend;
    logic        cfg_resize;

    // a write that changes the active size asks for a clearing pass
    assign cfg_resize = i_cfg_valid &&
                        (((i_cfg_index == CFG_WIDTH) && (i_cfg_data[8:0] != r_width)) ||
                         ((i_cfg_index == CFG_HEIGHT) && (i_cfg_data[8:0] != r_height)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width    <= RST_DIM;
            r_height   <= RST_DIM;
            r_hold     <= RST_HOLD;
            r_fade     <= RST_FADE;
            r_clr_pend <= 1'b1;
        end else begin
            if (cfg_resize) begin
                r_clr_pend <= 1'b1;
            end else if (i_cmd.clr_ack) begin
                r_clr_pend <= 1'b0;
            end
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_WIDTH:  r_width  <= i_cfg_data[8:0];
                    CFG_HEIGHT: r_height <= i_cfg_data[8:0];
                    CFG_HOLD:   r_hold   <= i_cfg_data;
                    CFG_FADE:   r_fade   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    logic [WB-1:0] w_eff;
    logic [HB-1:0] h_eff;
    assign w_eff = (32'(r_width) > MAX_WIDTH) ? WB'(MAX_WIDTH) : WB'(r_width);
    assign h_eff = (32'(r_height) > MAX_HEIGHT) ? HB'(MAX_HEIGHT) : HB'(r_height);

    // global state and current item
    logic [FB-1:0]      r_newest, r_frame;
    logic [TB-1:0]      r_tick;
    logic [1:0]         r_cmd;
    logic [7:0]         r_x, r_y;
    logic signed [15:0] r_s [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest <= '0;
            r_tick   <= '0;
        end else begin
            if (i_cmd.set_newest) begin
                r_newest <= r_frame;
            end
            if (i_cmd.tick_inc) begin
                r_tick <= r_tick + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd   <= i_command;
            r_x     <= i_pos_x;
            r_y     <= i_pos_y;
            r_frame <= FB'(i_frame_number);
            r_s[0]  <= i_sample_red;
            r_s[1]  <= i_sample_green;
            r_s[2]  <= i_sample_blue;
        end
    end

    logic          in_range;
    logic [AW-1:0] item_addr;
    assign in_range  = (32'(r_x) < 32'(w_eff)) && (32'(r_y) < 32'(h_eff));
    assign item_addr = AW'(32'(r_y) * MAX_WIDTH + 32'(r_x));

    // sweep position: in an area walk r_sweep equals r_row + r_sx; a full sweep steps r_sweep alone
    logic [AW-1:0] r_sweep, r_row;
    logic [WB-1:0] r_sx;
    logic [HB-1:0] r_sy;

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_init) begin
            r_sweep <= '0;
            r_row   <= '0;
            r_sx    <= '0;
            r_sy    <= '0;
        end else if (i_cmd.sweep_step) begin
            r_sweep <= r_sweep + 1'b1;
        end else if (i_cmd.area_step) begin
            if (r_sx == w_eff - 1'b1) begin
                r_sx    <= '0;
                r_sy    <= r_sy + 1'b1;
                r_row   <= r_row + AW'(MAX_WIDTH);
                r_sweep <= r_row + AW'(MAX_WIDTH);
            end else begin
                r_sx    <= r_sx + 1'b1;
                r_sweep <= r_sweep + 1'b1;
            end
        end
    end

    // stores
    logic          d_we, d_re, s_we, s_re;
    logic [AW-1:0] d_waddr, d_raddr;
    logic [DW-1:0] d_wdata, d_rdata;
    logic [TB-1:0] s_rdata;

    pfa_ram #(.WIDTH(DW), .DEPTH(NPIX)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_re    (d_re),
        .i_raddr (d_raddr),
        .o_rdata (d_rdata)
    );

    pfa_ram #(.WIDTH(TB), .DEPTH(NPIX)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (r_sweep),
        .i_wdata (r_tick),
        .i_re    (s_re),
        .i_raddr (r_sweep),
        .o_rdata (s_rdata)
    );

    logic signed [CB-1:0] rd_vis [3];
    logic signed [CB-1:0] rd_st  [3];
    logic [FB-1:0]        rd_vf, rd_sf;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rd_vis[c] = d_rdata[c*CB +: CB];
            rd_st[c]  = d_rdata[O_ST + c*CB +: CB];
        end
        rd_vf = d_rdata[O_VF +: FB];
        rd_sf = d_rdata[O_SF +: FB];
    end

    // age step
    logic          age_skip, age_clr, age_fade;
    logic [TB-1:0] age_val;
    logic [16:0]   age_limit;
    logic signed [CB-1:0] age_vis [3];
    logic [FB-1:0] age_vf;

    always_comb begin
        age_skip  = (rd_vf == '0) || (rd_vf >= r_newest);
        age_val   = r_tick - s_rdata;
        age_limit = {1'b0, r_hold} + {1'b0, r_fade};
        age_clr   = !age_skip && (32'(age_val) > 32'(age_limit));
        age_fade  = !age_skip && !age_clr && (32'(age_val) > 32'(r_hold));
        age_vf    = age_clr ? r_newest : rd_vf;
        for (int c = 0; c < 3; c++) begin
            if (age_clr) begin
                age_vis[c] = '0;
            end else if (age_fade) begin
                age_vis[c] = scale_9_10(rd_vis[c]);
            end else begin
                age_vis[c] = rd_vis[c];
            end
        end
    end

    // sample merge
    logic                 a_neg;
    logic signed [CB-1:0] a_vis [3];
    logic signed [CB-1:0] a_st  [3];
    logic [FB-1:0]        a_vf, a_sf;

    always_comb begin
        a_neg = r_s[0][15] | r_s[1][15] | r_s[2][15];
        a_vf  = rd_vf;
        a_sf  = rd_sf;
        for (int c = 0; c < 3; c++) begin
            a_vis[c] = rd_vis[c];
            a_st[c]  = rd_st[c];
        end
        if (rd_vf == r_frame) begin
            for (int c = 0; c < 3; c++) begin
                a_vis[c] = sat_add(rd_vis[c], r_s[c]);
            end
        end else if (a_neg) begin
            // negative sample of a newer frame goes to the stash
            if (rd_sf == r_frame) begin
                for (int c = 0; c < 3; c++) begin
                    a_st[c] = sat_add(rd_st[c], r_s[c]);
                end
            end else if (rd_sf < r_frame) begin
                a_sf = r_frame;
                for (int c = 0; c < 3; c++) begin
                    a_st[c] = sat_add('0, r_s[c]);
                end
            end
        end else begin
            a_vf = r_frame;
            if (rd_sf == r_newest) begin
                for (int c = 0; c < 3; c++) begin
                    a_vis[c] = sat_add(rd_st[c], r_s[c]);
                    a_st[c]  = '0;
                end
            end else begin
                for (int c = 0; c < 3; c++) begin
                    a_vis[c] = sat_add('0, r_s[c]);
                end
            end
        end
    end

    logic pix_add;
    assign pix_add = i_cmd.pix_wr && (r_cmd == CMD_ADD);

    always_comb begin
        d_re    = i_cmd.pix_rd | i_cmd.tick_rd;
        d_raddr = i_cmd.pix_rd ? item_addr : r_sweep;
        d_we    = pix_add | i_cmd.clear_wr | (i_cmd.tick_wr & (age_clr | age_fade));
        d_waddr = i_cmd.pix_wr ? item_addr : r_sweep;
        if (i_cmd.clear_wr) begin
            d_wdata = '0;
        end else if (i_cmd.pix_wr) begin
            d_wdata = {a_sf, a_st[2], a_st[1], a_st[0], a_vf, a_vis[2], a_vis[1], a_vis[0]};
        end else begin
            d_wdata = {rd_sf, rd_st[2], rd_st[1], rd_st[0], age_vf, age_vis[2], age_vis[1],
                       age_vis[0]};
        end
        s_re = i_cmd.tick_rd;
        s_we = i_cmd.restamp_wr | i_cmd.clear_wr | (i_cmd.tick_wr & age_clr);
    end

    // result and output register
    logic [15:0] r_res_r, r_res_g, r_res_b, r_res_f;
    logic        r_res_app;
    logic        r_out_valid;
    logic [15:0] r_out_r, r_out_g, r_out_b, r_out_f;
    logic        r_out_app;

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_zero) begin
            r_res_r   <= '0;
            r_res_g   <= '0;
            r_res_b   <= '0;
            r_res_f   <= '0;
            r_res_app <= i_cmd.res_applied;
        end else if (i_cmd.pix_wr) begin
            r_res_app <= 1'b1;
            if (r_cmd == CMD_READ) begin
                r_res_r <= sat16(rd_vis[0]);
                r_res_g <= sat16(rd_vis[1]);
                r_res_b <= sat16(rd_vis[2]);
                r_res_f <= 16'(rd_vf);
            end else begin
                r_res_r <= '0;
                r_res_g <= '0;
                r_res_b <= '0;
                r_res_f <= '0;
            end
        end
        if (i_cmd.emit) begin
            r_out_r   <= r_res_r;
            r_out_g   <= r_res_g;
            r_out_b   <= r_res_b;
            r_out_f   <= r_res_f;
            r_out_app <= r_res_app;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_red   = r_out_r;
    assign o_pixel_green = r_out_g;
    assign o_pixel_blue  = r_out_b;
    assign o_pixel_frame = r_out_f;
    assign o_applied     = r_out_app;

    always_comb begin
        o_stat.clr_pend   = r_clr_pend;
        o_stat.cmd        = r_cmd;
        o_stat.stale      = r_frame < r_newest;
        o_stat.newer      = r_frame > r_newest;
        o_stat.in_range   = in_range;
        o_stat.full_last  = r_sweep == AW'(NPIX - 1);
        o_stat.area_last  = (r_sx == w_eff - 1'b1) && (r_sy == h_eff - 1'b1);
        o_stat.area_empty = (w_eff == '0) || (h_eff == '0);
        o_stat.out_free   = !r_out_valid || i_out_ready;
    end

endmodule

@@ rtl/core/progressive_frame_accumulator.sv @@
// top level of the progressive frame accumulator
//
// A framebuffer for progressive rendering. Each input item is one command:
// add a Q4.12 sample to a pixel, age the active-area pixels by one tick, read a pixel,
// or clear the stores. Every item returns exactly one result item. Items
// are handled one at a time by a controller that drives a read-modify-write
// datapath over two one-write, one-read memories (pixel data and age stamp).
// Per item: an in-range sample or read is decoded with a memory read, then
// merged and written back, then its result is emitted; a sample from a
// newer frame first restamps every pixel of MAX_WIDTH*MAX_HEIGHT; an age
// tick walks the active area, reading each pixel and then writing it back;
// a clear sweeps all MAX_WIDTH*MAX_HEIGHT pixels.
// After reset, and after any write that changes image_width or
// image_height, a clearing pass over all MAX_WIDTH*MAX_HEIGHT pixels
// runs before the next item is accepted; configuration writes are always
// accepted. The result goes to an output register, so a finished result
// may wait while the next item is being accepted.
module progressive_frame_accumulator #(
    parameter int MAX_WIDTH  = pfa_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = pfa_pkg::DEF_MAX_HEIGHT,
    parameter int COLOR_BITS = pfa_pkg::DEF_COLOR_BITS,
    parameter int FRAME_BITS = pfa_pkg::DEF_FRAME_BITS,
    parameter int TIME_BITS  = pfa_pkg::DEF_TIME_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,   // pos_x, pos_y, frame_number, red, green, blue
    input  logic [1:0]  s_axis_tuser,   // command
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // pixel_red, pixel_green, pixel_blue, pixel_frame
    output logic [0:0]  m_axis_tuser    // applied
);
    import pfa_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    logic signed [15:0] px_r, px_g, px_b;
    logic [15:0]        px_f;
    logic               px_app;

    // configuration writes never stall
    assign o_cfg_ready = 1'b1;

    pfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    pfa_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .COLOR_BITS (COLOR_BITS),
        .FRAME_BITS (FRAME_BITS),
        .TIME_BITS  (TIME_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_command      (s_axis_tuser),
        .i_pos_x        (s_axis_tdata[7:0]),
        .i_pos_y        (s_axis_tdata[15:8]),
        .i_frame_number (s_axis_tdata[31:16]),
        .i_sample_red   (s_axis_tdata[47:32]),
        .i_sample_green (s_axis_tdata[63:48]),
        .i_sample_blue  (s_axis_tdata[79:64]),
        .i_out_ready    (m_axis_tready),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_out_valid    (m_axis_tvalid),
        .o_pixel_red    (px_r),
        .o_pixel_green  (px_g),
        .o_pixel_blue   (px_b),
        .o_pixel_frame  (px_f),
        .o_applied      (px_app)
    );

    // pack result fields, lowest first
    assign m_axis_tdata = {px_f, px_b, px_g, px_r};
    assign m_axis_tuser = px_app;

endmodule

@@ verif/tb_top.sv @@
// testbench for the progressive frame accumulator: random and directed items against a predictor
`timescale 1ns / 100ps

module tb_top;
    import pfa_pkg::*;

    localparam int NPIX      = 65536;
    localparam int CYC_LIMIT = 6000000;

    typedef struct {
        logic [1:0]         cmd;
        logic [7:0]         x;
        logic [7:0]         y;
        logic [15:0]        frame;
        logic signed [15:0] r, g, b;
    } t_pix_item;

    typedef struct {
        logic signed [15:0] r, g, b;
        logic [15:0]        frame;
        logic               applied;
    } t_pix_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = CFG_WIDTH;
    logic [15:0] i_cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = CMD_ADD;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    progressive_frame_accumulator i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    always #4 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // predicted framebuffer: its own copy of pixels, stash and registers
    // ---------------------------------------------------------------
    int          vis_c [NPIX][3];
    int unsigned vis_fr [NPIX];
    int          stash_c [NPIX][3];
    int unsigned stash_fr [NPIX];
    int unsigned stamp [NPIX];
    int unsigned newest;
    int unsigned ticks;
    int unsigned img_w = 256, img_h = 256, hold = 10, fade = 10;

    t_pix_item   pending_items[$];
    t_pix_result expected_pixels[$];
    int          err_cnt = 0;
    int          cyc = 0;

    function automatic int sat_c(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return int'(v);
    endfunction

    function automatic int fade_c(int v);
        longint m;
        m = (v < 0) ? -longint'(v) : longint'(v);
        m = (m * 9) / 10;
        return int'((v < 0) ? -m : m);
    endfunction

    function automatic int unsigned eff(int unsigned v);
        return (v > 256) ? 256 : v;
    endfunction

    function automatic void restamp_all();
        for (int i = 0; i < NPIX; i++) stamp[i] = ticks;
    endfunction

    // clear command and resize: wipe colors and frames, restamp, keep newest and tick count
    function automatic void wipe_stores();
        for (int i = 0; i < NPIX; i++) begin
            for (int c = 0; c < 3; c++) begin
                vis_c[i][c] = 0;
                stash_c[i][c] = 0;
            end
            vis_fr[i] = 0;
            stash_fr[i] = 0;
            stamp[i] = ticks;
        end
    endfunction

    // one age tick over the active area
    function automatic void age_all();
        int unsigned o, age;
        longint unsigned lim;
        lim = longint'(hold) + longint'(fade);
        ticks = (ticks + 1) & 16'hffff;
        for (int y = 0; y < eff(img_h); y++) begin
            for (int x = 0; x < eff(img_w); x++) begin
                o = y * 256 + x;
                if (vis_fr[o] == 0 || vis_fr[o] >= newest) continue;
                age = (ticks - stamp[o]) & 16'hffff;
                if (age > lim) begin
                    stamp[o] = ticks;
                    vis_fr[o] = newest;
                    for (int c = 0; c < 3; c++) vis_c[o][c] = 0;
                end else if (age > hold) begin
                    for (int c = 0; c < 3; c++) vis_c[o][c] = fade_c(vis_c[o][c]);
                end
            end
        end
    endfunction

    // sample merge: add, stash on a negative newer sample, replace on a positive one
    function automatic bit merge_sample(t_pix_item it);
        int unsigned o, fr;
        int s [3];
        bit neg;
        fr = it.frame;
        s[0] = it.r;
        s[1] = it.g;
        s[2] = it.b;
        if (fr < newest) return 1'b0;
        if (fr > newest) begin
            newest = fr;
            restamp_all();
        end
        if (it.x >= eff(img_w) || it.y >= eff(img_h)) return 1'b0;
        o = it.y * 256 + it.x;
        if (vis_fr[o] == fr) begin
            for (int c = 0; c < 3; c++) vis_c[o][c] = sat_c(longint'(vis_c[o][c]) + s[c]);
            return 1'b1;
        end
        neg = s[0] < 0 || s[1] < 0 || s[2] < 0;
        if (neg) begin
            if (stash_fr[o] == fr) begin
                for (int c = 0; c < 3; c++)
                    stash_c[o][c] = sat_c(longint'(stash_c[o][c]) + s[c]);
            end else if (stash_fr[o] < fr) begin
                stash_fr[o] = fr;
                for (int c = 0; c < 3; c++) stash_c[o][c] = s[c];
            end
            return 1'b1;
        end
        vis_fr[o] = fr;
        if (stash_fr[o] == newest) begin
            for (int c = 0; c < 3; c++) begin
                vis_c[o][c] = sat_c(longint'(stash_c[o][c]) + s[c]);
                stash_c[o][c] = 0;
            end
        end else begin
            for (int c = 0; c < 3; c++) vis_c[o][c] = s[c];
        end
        return 1'b1;
    endfunction

    function automatic void predict_pixel(t_pix_item it);
        t_pix_result res;
        int unsigned o;
        res = '{r: 0, g: 0, b: 0, frame: 0, applied: 0};
        case (it.cmd)
            CMD_ADD: res.applied = merge_sample(it);
            CMD_TICK: begin
                age_all();
                res.applied = 1'b1;
            end
            CMD_READ: begin
                if (it.x < eff(img_w) && it.y < eff(img_h)) begin
                    o = it.y * 256 + it.x;
                    res.r = 16'(vis_c[o][0]);
                    res.g = 16'(vis_c[o][1]);
                    res.b = 16'(vis_c[o][2]);
                    res.frame = 16'(vis_fr[o]);
                    res.applied = 1'b1;
                end
            end
            default: begin
                wipe_stores();
                res.applied = 1'b1;
            end
        endcase
        expected_pixels.insert(expected_pixels.size(), res);
    endfunction

    function automatic void apply_reg(logic [1:0] idx, logic [15:0] val);
        case (idx)
            CFG_WIDTH:  if (val[8:0] != img_w) begin img_w = 32'(val[8:0]); wipe_stores(); end
            CFG_HEIGHT: if (val[8:0] != img_h) begin img_h = 32'(val[8:0]); wipe_stores(); end
            CFG_HOLD:   hold = 32'(val);
            default:    fade = 32'(val);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // driver: bursts of items from the pending queue, random gaps between
    // ---------------------------------------------------------------
    t_pix_item cur_item;
    int        burst_left = 0;
    int        gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_pixel(cur_item);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= cur_item.cmd;
                    s_axis_tdata <= {cur_item.b, cur_item.g, cur_item.r, cur_item.frame,
                                     cur_item.y, cur_item.x};
                    if (burst_left <= 1) begin
                        // some bursts run back to back with no gap at all
                        burst_left <= $urandom_range(1, 24);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: receiver stall pattern and result check
    // ---------------------------------------------------------------
    int stall_mode = 0;
    int stall_left = 0;
    int stall_phase = 0;

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cyc);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_pix_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch("unexpected result item", 1, 0);
            end else begin
                want = expected_pixels.pop_front();
                if ($signed(m_axis_tdata[15:0]) != want.r)
                    report_mismatch("pixel_red", $signed(m_axis_tdata[15:0]), want.r);
                if ($signed(m_axis_tdata[31:16]) != want.g)
                    report_mismatch("pixel_green", $signed(m_axis_tdata[31:16]), want.g);
                if ($signed(m_axis_tdata[47:32]) != want.b)
                    report_mismatch("pixel_blue", $signed(m_axis_tdata[47:32]), want.b);
                if (m_axis_tdata[63:48] != want.frame)
                    report_mismatch("pixel_frame", m_axis_tdata[63:48], want.frame);
                if (m_axis_tuser[0] != want.applied)
                    report_mismatch("applied", m_axis_tuser[0], want.applied);
            end
        end
        // stall pattern: always ready, random, or periodic, in stretches
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(10, 200);
        end
        stall_left--;
        stall_phase++;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= (stall_phase % 5) < 2;
        endcase
    end

    // cycle limit
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT) begin
            $display("[progressive_frame_accumulator] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------
    int unsigned gen_newest = 0;
    int          newer_budget = 0;
    int          clear_budget = 0;

    function automatic void push_item(logic [1:0] cmd, int x, int y, int unsigned fr,
                                      int r, int g, int b);
        t_pix_item it;
        it.cmd = cmd;
        it.x = 8'(x);
        it.y = 8'(y);
        it.frame = 16'(fr);
        it.r = 16'(r);
        it.g = 16'(g);
        it.b = 16'(b);
        if (cmd == CMD_ADD && fr > gen_newest) gen_newest = fr;
        pending_items.insert(pending_items.size(), it);
    endfunction

    function automatic int rand_color();
        case ($urandom_range(0, 5))
            0: return 32767;
            1: return -32768;
            2: return $signed(16'($urandom()));
            default: return $urandom_range(0, 4000) - 1000;
        endcase
    endfunction

    // random adds mostly into the current frame, sometimes a new or stale one, plus reads, ticks and clears
    function automatic void gen_random(int n, int w, int h);
        int unsigned fr;
        int sel, r, g, b;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 58) begin
                if (newer_budget > 0 && $urandom_range(0, 60) == 0) begin
                    newer_budget--;
                    fr = (newer_budget == 0 && gen_newest < 65000) ? 65535
                         : gen_newest + $urandom_range(1, 3000);
                    if (fr > 65535) fr = 65535;
                end else if ($urandom_range(0, 9) == 0 && gen_newest > 0) begin
                    fr = $urandom_range(0, gen_newest - 1);
                end else begin
                    fr = gen_newest;
                end
                if ($urandom_range(0, 2) == 0) begin
                    r = rand_color();
                    g = rand_color();
                    b = rand_color();
                end else begin
                    r = $urandom_range(0, 32767);
                    g = $urandom_range(0, 32767);
                    b = $urandom_range(0, 32767);
                end
                push_item(CMD_ADD, $urandom_range(0, w), $urandom_range(0, h), fr, r, g, b);
            end else if (sel < 80) begin
                push_item(CMD_READ, $urandom_range(0, w), $urandom_range(0, h),
                          $urandom_range(0, 65535), rand_color(), rand_color(), rand_color());
            end else if (sel < 99 || clear_budget == 0) begin
                push_item(CMD_TICK, $urandom(), $urandom(), $urandom_range(0, 65535),
                          rand_color(), rand_color(), rand_color());
            end else begin
                clear_budget--;
                push_item(CMD_CLEAR, $urandom(), $urandom(), 0, 0, 0, 0);
            end
        end
    endfunction

    // sender pause: every pending item sent and every result in
    task automatic drain();
        do @(posedge i_clk);
        while (pending_items.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        apply_reg(idx, val);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        newest = 0;
        ticks = 0;
        wipe_stores();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full-size image with the reset registers
        push_item(CMD_READ, 255, 255, 0, 0, 0, 0);
        push_item(CMD_ADD, 0, 0, 0, 100, 200, 300);             // frame zero accumulates
        push_item(CMD_ADD, 255, 255, 0, 32767, 32767, -32768);
        push_item(CMD_ADD, 255, 255, 0, 32767, 1, -1);          // saturation both ways
        push_item(CMD_READ, 255, 255, 0, 0, 0, 0);
        push_item(CMD_ADD, 3, 0, 1, -500, 20, 30);              // newer frame: restamp, stash
        push_item(CMD_ADD, 3, 0, 1, -10, -20, 5);               // stash accumulates
        push_item(CMD_ADD, 3, 0, 1, 1000, 2000, 3000);          // replace, fold stash in
        push_item(CMD_READ, 3, 0, 0, 0, 0, 0);
        push_item(CMD_ADD, 3, 0, 1, 7, 7, 7);                   // own frame adds
        push_item(CMD_ADD, 5, 5, 0, 1, 1, 1);                   // stale frame dropped
        push_item(CMD_READ, 0, 0, 0, 0, 0, 0);                  // old frame still visible
        push_item(CMD_ADD, 0, 255, 1, 32767, 32767, 32767);     // column zero of the last row
        push_item(CMD_READ, 0, 255, 0, 0, 0, 0);
        push_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
        push_item(CMD_READ, 3, 0, 0, 0, 0, 0);
        drain();

        // small image, short hold and fade so pixels fade and clear
        write_reg(CFG_WIDTH, 16'd8);
        write_reg(CFG_HEIGHT, 16'd8);
        write_reg(CFG_HOLD, 16'd2);
        write_reg(CFG_FADE, 16'd3);
        push_item(CMD_ADD, 8, 2, 1, 5, 5, 5);                   // column out of range
        push_item(CMD_ADD, 2, 8, 2, 5, 5, 5);                   // newer frame out of range
        push_item(CMD_READ, 8, 8, 0, 0, 0, 0);
        push_item(CMD_ADD, 1, 1, 2, 9000, -9000, 4000);
        push_item(CMD_ADD, 2, 2, 3, 20000, 20000, 20000);       // leaves frame 2 stale
        for (int i = 0; i < 8; i++) push_item(CMD_TICK, 0, 0, 0, 0, 0, 0);
        push_item(CMD_READ, 1, 1, 0, 0, 0, 0);
        newer_budget = 2;
        clear_budget = 0;
        gen_random(200, 9, 9);
        drain();

        // one column, zero hold and fade
        write_reg(CFG_WIDTH, 16'd1);
        write_reg(CFG_HEIGHT, 16'd256);
        write_reg(CFG_HOLD, 16'd0);
        write_reg(CFG_FADE, 16'd0);
        newer_budget = 2;
        clear_budget = 1;
        gen_random(160, 2, 255);
        drain();

        // one row, largest hold and fade
        write_reg(CFG_WIDTH, 16'd256);
        write_reg(CFG_HEIGHT, 16'd1);
        write_reg(CFG_HOLD, 16'd65535);
        write_reg(CFG_FADE, 16'd65535);
        newer_budget = 2;
        clear_budget = 0;
        gen_random(150, 255, 2);
        drain();
        repeat (20) @(posedge i_clk);

        if (err_cnt == 0 && expected_pixels.size() == 0) begin
            $display("[progressive_frame_accumulator] OK");
        end else begin
            $display("[progressive_frame_accumulator] ERROR");
        end
        $finish;
    end

endmodule
